>>> sv/utf8v_pkg.sv
// utf8v_pkg: shared types, constants and codes for the utf-8 stream validator
// no dependencies; imported by utf8v_lane, utf8v_merge and utf8_stream_validator_unit

package utf8v_pkg;

    localparam int LANES_DEF = 8;

    localparam logic [7:0] CONT_MIN     = 8'h80;
    localparam logic [7:0] CONT_MAX     = 8'hBF;
    localparam logic [7:0] LEAD_2_MIN   = 8'hC2;
    localparam logic [7:0] LEAD_2_MAX   = 8'hDF;
    localparam logic [7:0] LEAD_3_MIN   = 8'hE0;
    localparam logic [7:0] LEAD_3_MAX   = 8'hEF;
    localparam logic [7:0] LEAD_ED      = 8'hED;
    localparam logic [7:0] LEAD_4_MIN   = 8'hF0;
    localparam logic [7:0] LEAD_4_MAX   = 8'hF4;
    localparam logic [7:0] AFTER_E0_MIN = 8'hA0;
    localparam logic [7:0] AFTER_ED_MAX = 8'h9F;
    localparam logic [7:0] AFTER_F0_MIN = 8'h90;
    localparam logic [7:0] AFTER_F4_MAX = 8'h8F;

    typedef enum logic [2:0] {
        CLS_ANY = 3'd0,
        CLS_E0  = 3'd1,
        CLS_ED  = 3'd2,
        CLS_F0  = 3'd3,
        CLS_F4  = 3'd4
    } byte_class_t;

    typedef struct packed {
        logic        is_ascii;
        logic        bad_lead;
        logic [1:0]  lead_left;
        byte_class_t lead_cls;
        logic        ok_any;
        logic        ok_e0;
        logic        ok_ed;
        logic        ok_f0;
        logic        ok_f4;
    } lane_info_t;

    typedef struct packed {
        logic [1:0]  left;
        byte_class_t cls;
        logic        err;
    } scan_state_t;

endpackage

>>> sv/utf8v_lane.sv
// utf8v_lane: per-byte classifier, one instance per byte lane
// depends on utf8v_pkg

module utf8v_lane
    import utf8v_pkg::*;
(
    input  logic [7:0] data_byte,
    output lane_info_t info
);

    always_comb
    begin
        info.is_ascii  = (data_byte < CONT_MIN);
        info.bad_lead  = ((data_byte >= CONT_MIN) && (data_byte < LEAD_2_MIN))
                         || (data_byte > LEAD_4_MAX);
        info.lead_left = 2'd0;
        info.lead_cls  = CLS_ANY;
        if ((data_byte >= LEAD_2_MIN) && (data_byte <= LEAD_2_MAX))
        begin
            info.lead_left = 2'd1;
        end
        else if ((data_byte >= LEAD_3_MIN) && (data_byte <= LEAD_3_MAX))
        begin
            info.lead_left = 2'd2;
            if (data_byte == LEAD_3_MIN)
            begin
                info.lead_cls = CLS_E0;
            end
            else if (data_byte == LEAD_ED)
            begin
                info.lead_cls = CLS_ED;
            end
        end
        else if ((data_byte >= LEAD_4_MIN) && (data_byte <= LEAD_4_MAX))
        begin
            info.lead_left = 2'd3;
            if (data_byte == LEAD_4_MIN)
            begin
                info.lead_cls = CLS_F0;
            end
            else if (data_byte == LEAD_4_MAX)
            begin
                info.lead_cls = CLS_F4;
            end
        end
        info.ok_any = (data_byte >= CONT_MIN) && (data_byte <= CONT_MAX);
        info.ok_e0  = (data_byte >= AFTER_E0_MIN) && (data_byte <= CONT_MAX);
        info.ok_ed  = (data_byte >= CONT_MIN) && (data_byte <= AFTER_ED_MAX);
        info.ok_f0  = (data_byte >= AFTER_F0_MIN) && (data_byte <= CONT_MAX);
        info.ok_f4  = (data_byte >= CONT_MIN) && (data_byte <= AFTER_F4_MAX);
    end

endmodule

>>> sv/utf8v_merge.sv
// utf8v_merge: chains the sequence state through the lane results in stream order
// depends on utf8v_pkg and the lane_info_t produced by utf8v_lane

module utf8v_merge
    import utf8v_pkg::*;
#(
    parameter int LANES = LANES_DEF
)
(
    input  scan_state_t state_in,
    input  lane_info_t  info [LANES],
    input  logic [LANES-1:0] active,
    output scan_state_t state_out
);

    function automatic scan_state_t step(input scan_state_t st, input lane_info_t li);
        scan_state_t nx;
        logic        ok;
        nx = st;
        ok = li.ok_any;
        if (st.left != 2'd0)
        begin
            case (st.cls)
                CLS_E0:  ok = li.ok_e0;
                CLS_ED:  ok = li.ok_ed;
                CLS_F0:  ok = li.ok_f0;
                CLS_F4:  ok = li.ok_f4;
                default: ok = li.ok_any;
            endcase
            nx.cls = CLS_ANY;
            if (!ok)
            begin
                nx.err  = 1'b1;
                nx.left = 2'd0;
            end
            else
            begin
                nx.left = st.left - 2'd1;
            end
        end
        else if (li.bad_lead)
        begin
            nx.err = 1'b1;
        end
        else if (!li.is_ascii)
        begin
            nx.left = li.lead_left;
            nx.cls  = li.lead_cls;
        end
        return nx;
    endfunction

    always_comb
    begin
        state_out = state_in;
        for (int i = 0; i < LANES; i++)
        begin
            if (active[i])
            begin
                state_out = step(state_out, info[i]);
            end
        end
    end

endmodule

>>> sv/utf8_stream_validator_unit.sv
// utf8_stream_validator_unit: top level of the utf-8 stream validator
// depends on utf8v_pkg, utf8v_lane and utf8v_merge

// Checks that a byte stream is well-formed UTF-8. Each input item carries up to
// LANES bytes (byte_count of them valid, a larger count meaning all lanes); a
// multi-byte sequence may run across items. The item with tlast high closes the
// text: it yields one result item whose bit 0 is 1 when the whole text was
// well-formed with no sequence left open, and the checker then starts afresh.
// Items without tlast yield nothing. One item is taken every clock cycle; the
// cycle is set by the classify-and-chain path through all LANES byte lanes.
// The result waits in an output register; while it waits a closing item is held
// off but other items are still taken. There is no clearing pass after reset.

module utf8_stream_validator_unit
    import utf8v_pkg::*;
#(
    parameter int LANES = LANES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // byte_0 .. byte_(LANES-1), byte_count, zero fill
    input  logic [((LANES*8+$clog2(LANES+1)+7)/8)*8-1:0] s_tdata,
    input  logic s_tlast,
    output logic m_tvalid,
    input  logic m_tready,
    // text_valid, zero fill
    output logic [7:0] m_tdata
);

    localparam int CNT_W = $clog2(LANES + 1);

    logic [CNT_W-1:0] byte_count;
    logic [LANES-1:0] lane_active;
    lane_info_t       info [LANES];
    scan_state_t      state_reg;
    scan_state_t      state_next;
    scan_state_t      merged;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             text_valid_reg;
    logic             text_valid_next;
    logic             accept;

    assign byte_count = s_tdata[LANES*8 +: CNT_W];

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        assign lane_active[i] = (CNT_W'(i) < byte_count);
        utf8v_lane u_lane
        (
            .data_byte (s_tdata[i*8 +: 8]),
            .info      (info[i])
        );
    end

    utf8v_merge #(.LANES(LANES)) u_merge
    (
        .state_in  (state_reg),
        .info      (info),
        .active    (lane_active),
        .state_out (merged)
    );

    assign s_tready = !out_valid_reg || m_tready || !s_tlast;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, text_valid_reg};

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        text_valid_next = text_valid_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                state_next      = '{left: 2'd0, cls: CLS_ANY, err: 1'b0};
                out_valid_next  = 1'b1;
                text_valid_next = !merged.err && (merged.left == 2'd0);
            end
            else
            begin
                state_next = merged;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= '{left: 2'd0, cls: CLS_ANY, err: 1'b0};
            out_valid_reg  <= 1'b0;
            text_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            text_valid_reg <= text_valid_next;
        end
    end

    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> m_tvalid)
        else $error("closing item gave no result");

    a_end_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> (state_reg.left == 2'd0) && !state_reg.err
                              && (state_reg.cls == CLS_ANY))
        else $error("state not cleared after closing item");

    a_class_needs_two_left: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.cls != CLS_ANY |-> state_reg.left >= 2'd2)
        else $error("narrow class held without two continuations owed");

    a_no_drop_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(text_valid_reg))
        else $error("pending result lost or changed");

endmodule
